// ===== hdl/sgs_pkg.sv =====
// Shared types, constants and codes for the start gate scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package sgs_pkg;

   localparam int MAX_GATES_DEF = 64;
   localparam int TIME_W = 17;
   localparam int CNT_W = 7;
   localparam int GATE_W = 9; // signed gate index
   localparam logic [TIME_W-1:0] DAY_LAST = 17'd86399;
   localparam logic [TIME_W-1:0] TIME_MAX = 17'd131071;

   // commands
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_ARM = 2'd1;
   localparam logic [1:0] CMD_PILOT = 2'd2;

   // modes
   localparam logic [1:0] MODE_FIXED = 2'd1;
   localparam logic [1:0] MODE_PILOT = 2'd2;

   // events
   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_COUNTDOWN = 3'd1;
   localparam logic [2:0] EV_GATE = 3'd2;
   localparam logic [2:0] EV_LAST = 3'd3;
   localparam logic [2:0] EV_ONLY = 3'd4;
   localparam logic [2:0] EV_CLOSED = 3'd5;

   // register indexes
   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_OPEN = 3'd1;
   localparam logic [2:0] REG_CLOSE = 3'd2;
   localparam logic [2:0] REG_INTERVAL = 3'd3;
   localparam logic [2:0] REG_COUNT = 3'd4;
   localparam logic [2:0] REG_WAIT = 3'd5;
   localparam logic [2:0] REG_WINDOW = 3'd6;
   localparam logic [2:0] REG_FLAGS = 3'd7;

   // countdown levels in seconds
   function automatic logic [11:0] level_secs(input logic [2:0] i);
      case (i)
         3'd0: level_secs = 12'd60;
         3'd1: level_secs = 12'd300;
         3'd2: level_secs = 12'd600;
         3'd3: level_secs = 12'd1800;
         default: level_secs = 12'd3600;
      endcase
   endfunction

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the command
      logic arm_init; // load schedule bases, start arming
      logic arm_step; // test one gate against the time
      logic tick_eval;// evaluate tick in one step
      logic pilot;    // pilot trigger update
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic arm_done;
      logic gates_used; // gates take part in the task
      logic armed;      // next gate index is not negative
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/start_gate_scheduler_core.sv =====
// Start gate scheduler, top level: joins controller and datapath.
// Depends on sgs_pkg, sgs_ctrl and sgs_datapath.
// One item at a time: a tick or pilot trigger passes the decode state, then
// the done state, before its result is valid; a re-arm (or a tick that arms)
// passes decode, arm, the arming walk that tests one gate per cycle, and done.
// The next item is taken in the cycle after the result has been taken.
// Configuration is always ready; write it only while no item is in flight.
`default_nettype none
module start_gate_scheduler_core #(
   parameter int MAX_GATES = sgs_pkg::MAX_GATES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [10:0] csr_data,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [16:0] req_local_time_s,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic [2:0] rsp_alert_level,
   output logic rsp_before_first_gate,
   output logic [6:0] rsp_gate_number,
   output logic signed [6:0] rsp_active_gate,
   output logic rsp_gate_valid,
   output logic rsp_wait_for_pilot
);
   import sgs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sgs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   sgs_datapath #(.MAX_GATES(MAX_GATES)) u_dp (
      .clock, .reset, .csr_valid, .csr_index, .csr_data,
      .req_command, .req_local_time_s, .cmd, .sts,
      .rsp_event_res, .rsp_alert_level, .rsp_before_first_gate,
      .rsp_gate_number, .rsp_active_gate, .rsp_gate_valid, .rsp_wait_for_pilot
   );
endmodule
`default_nettype wire

// ===== hdl/sgs_datapath.sv =====
// Datapath of the start gate scheduler: registers, schedule state, arithmetic.
// Depends on sgs_pkg; driven by sgs_ctrl through cmd_type/sts_type.
`default_nettype none
module sgs_datapath #(
   parameter int MAX_GATES = sgs_pkg::MAX_GATES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_valid,
   input  wire logic [2:0] csr_index,
   input  wire logic [10:0] csr_data,
   input  wire logic [1:0] req_command,
   input  wire logic [16:0] req_local_time_s,
   input  wire sgs_pkg::cmd_type cmd,
   output sgs_pkg::sts_type sts,
   output logic [2:0] rsp_event_res,
   output logic [2:0] rsp_alert_level,
   output logic rsp_before_first_gate,
   output logic [6:0] rsp_gate_number,
   output logic signed [6:0] rsp_active_gate,
   output logic rsp_gate_valid,
   output logic rsp_wait_for_pilot
);
   import sgs_pkg::*;

   localparam logic [CNT_W-1:0] MAXG =
      (MAX_GATES > 64) ? CNT_W'(64) : CNT_W'(MAX_GATES);

   // configuration registers
   logic [1:0] mode_ff;
   logic [10:0] open_ff, close_ff;
   logic [7:0] intv_ff, wait_ff, win_ff;
   logic [6:0] cnt_set_ff;
   logic [1:0] flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0; open_ff <= 11'd720; close_ff <= 11'd1439;
         intv_ff <= 8'd30; cnt_set_ff <= 7'd0; wait_ff <= 8'd5;
         win_ff <= 8'd10; flags_ff <= 2'd0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODE: mode_ff <= csr_data[1:0];
            REG_OPEN: open_ff <= csr_data;
            REG_CLOSE: close_ff <= csr_data;
            REG_INTERVAL: intv_ff <= csr_data[7:0];
            REG_COUNT: cnt_set_ff <= csr_data[6:0];
            REG_WAIT: wait_ff <= csr_data[7:0];
            REG_WINDOW: win_ff <= csr_data[7:0];
            REG_FLAGS: flags_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // schedule state
   logic signed [GATE_W-1:0] next_ff;
   logic [TIME_W-1:0] open_t_ff, close_t_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [4:0] alert_ff;
   // command capture and arming walk
   logic [1:0] cmd_ff;
   logic [TIME_W-1:0] t_ff;
   logic [CNT_W-1:0] g_ff;
   logic [TIME_W:0] gate_t_ff; // time of gate g
   logic [13:0] intv_s_ff;     // interval in seconds
   logic arm_done_ff;

   // tick evaluation: gate time of next_gate is computed by a multiply
   logic [TIME_W+7:0] gate_at_next;
   always_comb gate_at_next = {8'd0, open_t_ff} + next_ff[CNT_W-1:0] * intv_s_ff;

   logic gates_used;
   always_comb begin
      if (!flags_ff[0]) gates_used = 1'b0;
      else if (mode_ff == MODE_PILOT) gates_used = 1'b1;
      else if (!flags_ff[1]) gates_used = 1'b0;
      else gates_used = cnt_ff != '0;
   end

   logic signed [TIME_W+9:0] diff;
   logic [15:0] q3;
   always_comb begin
      diff = $signed({1'b0, gate_at_next}) - $signed({10'd0, t_ff});
      q3 = 16'(({2'd0, intv_s_ff} * 16'd3) >> 2);
   end

   // result registers
   logic [2:0] ev_ff, lvl_ff;
   logic first_ff;
   logic [6:0] num_ff;

   // fixed schedule bases in seconds; close clamped to the last second of the day
   logic [TIME_W:0] fixed_open, fixed_close;
   logic [TIME_W-1:0] fixed_close_c;
   always_comb begin
      fixed_open = {7'd0, open_ff} * 18'd60;
      fixed_close = {7'd0, close_ff} * 18'd60;
      fixed_close_c = (fixed_close > {1'b0, DAY_LAST}) ? DAY_LAST
                      : fixed_close[TIME_W-1:0];
   end

   logic [TIME_W+1:0] po, pc;
   always_comb begin
      po = {2'd0, t_ff} + {11'd0, wait_ff} * 19'd60;
      if (po > {2'd0, TIME_MAX}) po = {2'd0, TIME_MAX};
      pc = po + {11'd0, win_ff} * 19'd60;
      if (pc > {2'd0, TIME_MAX}) pc = {2'd0, TIME_MAX};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= -GATE_W'(1); open_t_ff <= '0; close_t_ff <= DAY_LAST;
         cnt_ff <= '0; alert_ff <= '0; arm_done_ff <= 1'b0;
         ev_ff <= EV_NONE; lvl_ff <= '0; first_ff <= 1'b0; num_ff <= '0;
         cmd_ff <= CMD_TICK; t_ff <= '0; g_ff <= '0; gate_t_ff <= '0;
         intv_s_ff <= '0;
      end else begin
         // capture the item
         if (cmd.load) begin
            cmd_ff <= req_command; t_ff <= req_local_time_s;
            ev_ff <= EV_NONE; lvl_ff <= '0; first_ff <= 1'b0; num_ff <= '0;
            intv_s_ff <= {6'd0, intv_ff} * 14'd60;
            arm_done_ff <= 1'b0;
         end
         // load schedule bases and settle the quick answers
         if (cmd.arm_init) begin
            g_ff <= '0;
            if (mode_ff == MODE_FIXED) begin
               open_t_ff <= fixed_open[TIME_W-1:0];
               close_t_ff <= fixed_close_c;
               cnt_ff <= (cnt_set_ff > MAXG) ? MAXG : cnt_set_ff;
               gate_t_ff <= fixed_open;
               if (t_ff > fixed_close_c) begin
                  next_ff <= -GATE_W'(1); arm_done_ff <= 1'b1;
               end else if ({1'b0, t_ff} < fixed_open) begin
                  next_ff <= '0; arm_done_ff <= 1'b1;
               end
            end else begin
               open_t_ff <= '0; close_t_ff <= DAY_LAST; cnt_ff <= '0;
               gate_t_ff <= '0;
               // count 0: no gate can be ahead
               next_ff <= (t_ff > DAY_LAST) ? -GATE_W'(1) : -GATE_W'(2);
               arm_done_ff <= 1'b1;
            end
         end
         // walk one gate per cycle
         if (cmd.arm_step && !arm_done_ff) begin
            if (g_ff >= cnt_ff) begin
               next_ff <= -GATE_W'(2); arm_done_ff <= 1'b1;
            end else if ({1'b0, t_ff} < gate_t_ff) begin
               next_ff <= GATE_W'(g_ff) - GATE_W'(1); arm_done_ff <= 1'b1;
            end else begin
               g_ff <= g_ff + 1'b1;
               gate_t_ff <= gate_t_ff + (TIME_W+1)'(intv_s_ff);
            end
         end
         // one tick with an armed schedule
         if (cmd.tick_eval) begin
            if (t_ff >= close_t_ff) begin
               next_ff <= -GATE_W'(1); ev_ff <= EV_CLOSED;
            end else if (next_ff < $signed({2'b0, cnt_ff})) begin
               if (diff <= 0) begin
                  next_ff <= next_ff + 1'b1;
                  alert_ff <= '0;
                  if (next_ff + 1'b1 == $signed({2'b0, cnt_ff}) - 1) ev_ff <= EV_LAST;
                  else if (cnt_ff == 7'd1) ev_ff <= EV_ONLY;
                  else begin
                     ev_ff <= EV_GATE; num_ff <= 7'(next_ff + 1'b1);
                  end
               end else begin : alerts
                  logic stop;
                  logic [4:0] a;
                  stop = 1'b0;
                  a = alert_ff;
                  for (int i = 0; i < 5; i++) begin
                     if (!stop) begin
                        if (a[i]) stop = 1'b1;
                        else if (diff <= $signed({15'd0, level_secs(3'(i))})) begin
                           a[i] = 1'b1;
                           if (!(next_ff > 0 && {4'd0, level_secs(3'(i))} > q3)) begin
                              ev_ff <= EV_COUNTDOWN; lvl_ff <= 3'(i);
                              first_ff <= next_ff == 0; stop = 1'b1;
                           end
                        end
                     end
                  end
                  alert_ff <= a;
               end
            end
         end
         // pilot trigger
         if (cmd.pilot) begin
            open_t_ff <= po[TIME_W-1:0]; close_t_ff <= pc[TIME_W-1:0];
            next_ff <= '0; cnt_ff <= 7'd1;
         end
      end
   end

   // status outputs from the current state
   logic valid_now;
   always_comb begin
      if (!gates_used) valid_now = 1'b1;
      else if (mode_ff == MODE_PILOT && open_t_ff == '0) valid_now = 1'b0;
      else if (t_ff >= close_t_ff) valid_now = 1'b0;
      else valid_now = t_ff >= open_t_ff;
   end

   assign sts.command = cmd_ff;
   assign sts.arm_done = arm_done_ff;
   assign sts.gates_used = gates_used;
   assign sts.armed = !next_ff[GATE_W-1];
   assign rsp_event_res = ev_ff;
   assign rsp_alert_level = lvl_ff;
   assign rsp_before_first_gate = first_ff;
   assign rsp_gate_number = num_ff;
   assign rsp_active_gate = (next_ff < 0 || next_ff >= $signed({2'b0, cnt_ff})) ?
      -7'sd1 : 7'(next_ff - 1'b1);
   assign rsp_gate_valid = valid_now;
   assign rsp_wait_for_pilot = mode_ff == MODE_PILOT && (next_ff < 0 || cnt_ff == '0);

`ifndef SYNTHESIS
   a_pilot_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pilot |=> cnt_ff == 7'd1) else $error("pilot count");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 7'd64) else $error("count range");
   a_close_load: assert property (@(posedge clock) disable iff (reset)
      cmd.arm_init && mode_ff != MODE_FIXED |=> close_t_ff == DAY_LAST)
      else $error("close reload");
`endif
endmodule
`default_nettype wire

// ===== hdl/sgs_ctrl.sv =====
// Controller of the start gate scheduler: handshakes and sequencing.
// Depends on sgs_pkg; commands sgs_datapath.
`default_nettype none
module sgs_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire sgs_pkg::sts_type sts,
   output sgs_pkg::cmd_type cmd
);
   import sgs_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ARM = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic out_ff, out_in;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff;
      cmd = '0;
      req_ready = state_ff == S_IDLE && !out_ff;
      if (out_ff && rsp_ready) out_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.load = 1'b1; state_in = S_DECODE;
         end
         S_DECODE: begin
            case (sts.command)
               CMD_TICK: begin
                  if (!sts.gates_used) state_in = S_DONE;
                  else if (!sts.armed) state_in = S_ARM;
                  else begin cmd.tick_eval = 1'b1; state_in = S_DONE; end
               end
               CMD_ARM: state_in = S_ARM;
               CMD_PILOT: begin cmd.pilot = 1'b1; state_in = S_DONE; end
               default: state_in = S_DONE;
            endcase
         end
         S_ARM: begin cmd.arm_init = 1'b1; state_in = S_WALK; end
         S_WALK: begin
            if (sts.arm_done) state_in = S_DONE;
            else cmd.arm_step = 1'b1;
         end
         S_DONE: begin out_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_ff <= 1'b0;
      end else begin
         state_ff <= state_in; out_ff <= out_in;
      end
   end
   assign rsp_valid = out_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("accept while result pending");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid) else $error("result lost");
   a_walk_from_arm: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ARM |=> state_ff == S_WALK) else $error("arm order");
`endif
endmodule
`default_nettype wire

// ===== sim/sgs_checker.sv =====
// Result checker for the start gate scheduler: watches the command, result and
// register write channels, predicts each result and compares it. Depends on sgs_pkg.
`timescale 1ns / 100ps
module sgs_checker (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [10:0] csr_data,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [1:0] req_command,
   input  logic [16:0] req_local_time_s,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [2:0] rsp_event_res,
   input  logic [2:0] rsp_alert_level,
   input  logic rsp_before_first_gate,
   input  logic [6:0] rsp_gate_number,
   input  logic [6:0] rsp_active_gate,
   input  logic rsp_gate_valid,
   input  logic rsp_wait_for_pilot,
   output int fail_count,
   output int pending_count
);
   import sgs_pkg::*;

   typedef struct packed {
      logic [2:0] ev;
      logic [2:0] lvl;
      logic first;
      logic [6:0] num;
      logic [6:0] act;
      logic valid;
      logic wait_p;
   } gate_status_type;

   gate_status_type status_q[$];

   // register copies
   int mode_r, open_r, close_r, intv_r, count_r, wait_r, win_r, flags_r;
   // schedule state
   int nxt, t_open, t_close, n_gates;
   logic [4:0] alerted;

   function automatic int level_time(int i);
      case (i)
         0: return 60;
         1: return 300;
         2: return 600;
         3: return 1800;
         default: return 3600;
      endcase
   endfunction

   function automatic int gate_time(int g);
      return t_open + g * intv_r * 60;
   endfunction

   function automatic bit gates_on();
      if (!flags_r[0]) return 0;
      if (mode_r == MODE_PILOT) return 1;
      if (!flags_r[1]) return 0;
      return n_gates > 0;
   endfunction

   function automatic int arm_schedule(int t);
      int g;
      if (mode_r == MODE_FIXED) begin
         t_open = open_r * 60;
         t_close = close_r * 60;
         n_gates = count_r > MAX_GATES_DEF ? MAX_GATES_DEF : count_r;
      end else begin
         n_gates = 0;
         t_open = 0;
         t_close = DAY_LAST;
      end
      if (t_close > DAY_LAST) t_close = DAY_LAST;
      if (t > t_close) return -1;
      if (t < t_open) return 0;
      for (g = 0; g < n_gates; g++)
         if (t < gate_time(g)) return g - 1;
      return -2;
   endfunction

   // walk the schedule for one tick; fills event fields of s
   function automatic void tick_schedule(int t, inout gate_status_type s);
      int diff, q3;
      if (!gates_on()) return;
      if (nxt < 0) begin
         nxt = arm_schedule(t);
         return;
      end
      if (t >= t_close) begin
         nxt = -1;
         s.ev = EV_CLOSED;
         return;
      end
      if (nxt >= n_gates) return;
      diff = gate_time(nxt) - t;
      if (diff <= 0) begin
         nxt++;
         alerted = '0;
         if (nxt == n_gates - 1) s.ev = EV_LAST;
         else if (n_gates == 1) s.ev = EV_ONLY;
         else begin
            s.ev = EV_GATE;
            s.num = 7'(nxt);
         end
         return;
      end
      q3 = intv_r * 60 * 3 / 4;
      for (int i = 0; i < 5; i++) begin
         if (alerted[i]) return;
         if (diff > level_time(i)) continue;
         alerted[i] = 1'b1;
         if (nxt > 0 && level_time(i) > q3) continue;
         s.ev = EV_COUNTDOWN;
         s.lvl = 3'(i);
         s.first = (nxt == 0);
         return;
      end
   endfunction

   function automatic gate_status_type predict_status(logic [1:0] cmd, int t);
      gate_status_type s;
      int o, c, act;
      s = '0;
      if (cmd == CMD_TICK) tick_schedule(t, s);
      else if (cmd == CMD_ARM) nxt = arm_schedule(t);
      else if (cmd == CMD_PILOT) begin
         o = t + wait_r * 60;
         if (o > TIME_MAX) o = TIME_MAX;
         c = o + win_r * 60;
         if (c > TIME_MAX) c = TIME_MAX;
         t_open = o;
         t_close = c;
         nxt = 0;
         n_gates = 1;
      end
      act = (nxt < 0 || nxt >= n_gates) ? -1 : nxt - 1;
      s.act = act[6:0];
      s.wait_p = (mode_r == MODE_PILOT) && (nxt < 0 || n_gates < 1);
      if (!gates_on()) s.valid = 1;
      else if (mode_r == MODE_PILOT && t_open == 0) s.valid = 0;
      else s.valid = (t < t_close) && (t >= t_open);
      return s;
   endfunction

   always @(posedge clock) begin
      gate_status_type exp_s, got;
      if (reset) begin
         mode_r = 0; open_r = 720; close_r = 1439; intv_r = 30;
         count_r = 0; wait_r = 5; win_r = 10; flags_r = 0;
         nxt = -1; t_open = 0; t_close = DAY_LAST; n_gates = 0; alerted = '0;
         status_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE: mode_r = csr_data[1:0];
               REG_OPEN: open_r = csr_data;
               REG_CLOSE: close_r = csr_data;
               REG_INTERVAL: intv_r = csr_data[7:0];
               REG_COUNT: count_r = csr_data[6:0];
               REG_WAIT: wait_r = csr_data[7:0];
               REG_WINDOW: win_r = csr_data[7:0];
               REG_FLAGS: flags_r = csr_data[1:0];
               default: ;
            endcase
         end
         // compare result against oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = {rsp_event_res, rsp_alert_level, rsp_before_first_gate, rsp_gate_number,
                   rsp_active_gate, rsp_gate_valid, rsp_wait_for_pilot};
            if (status_q.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_s = status_q.pop_front();
               if (got !== exp_s) begin
                  $display("%0t: mismatch expected ev=%0d lvl=%0d first=%0d num=%0d act=%0d valid=%0d wait=%0d",
                     $time, exp_s.ev, exp_s.lvl, exp_s.first, exp_s.num, $signed(exp_s.act),
                     exp_s.valid, exp_s.wait_p);
                  $display("%0t:          actual   ev=%0d lvl=%0d first=%0d num=%0d act=%0d valid=%0d wait=%0d",
                     $time, got.ev, got.lvl, got.first, got.num, $signed(got.act),
                     got.valid, got.wait_p);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict accepted command
         if (req_valid && req_ready)
            status_q.push_back(predict_status(req_command, int'(req_local_time_s)));
         pending_count <= status_q.size();
      end
   end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top for start_gate_scheduler_core: clock, reset, register setup,
// command stimulus and verdict. Depends on sgs_pkg, sgs_checker and the block.
`timescale 1ns / 100ps
module tb_top;
   import sgs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [10:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [16:0] req_local_time_s = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_event_res, rsp_alert_level;
   logic rsp_before_first_gate, rsp_gate_valid, rsp_wait_for_pilot;
   logic [6:0] rsp_gate_number;
   logic signed [6:0] rsp_active_gate;
   int fail_count, pending_count;
   bit stim_done = 0;
   bit long_hold = 0;

   always #5 clock = ~clock;

   start_gate_scheduler_core u_top (.*);

   sgs_checker u_checker (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_command, .req_local_time_s,
      .rsp_valid, .rsp_ready, .rsp_event_res, .rsp_alert_level,
      .rsp_before_first_gate, .rsp_gate_number, .rsp_active_gate,
      .rsp_gate_valid, .rsp_wait_for_pilot, .fail_count, .pending_count
   );

   // mostly short gaps, a few long ones, some runs without gaps
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // hold valid across back-to-back writes; load_regs drops it at the end
   task automatic write_reg(logic [2:0] idx, int val);
      csr_index <= idx;
      csr_data <= val[10:0];
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drop the request, wait for all results, then let the block settle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0 || req_valid) @(posedge clock);
      repeat (MAX_GATES_DEF + 10) @(posedge clock);
   endtask

   // valid stays high into the next item when there is no gap
   task automatic send_item(logic [1:0] cmd, int t);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_command <= cmd;
      req_local_time_s <= t[16:0];
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_regs(int mode, int op, int cl, int iv, int cnt, int wt, int wn,
                            int fl);
      write_reg(REG_MODE, mode);
      write_reg(REG_OPEN, op);
      write_reg(REG_CLOSE, cl);
      write_reg(REG_INTERVAL, iv);
      write_reg(REG_COUNT, cnt);
      write_reg(REG_WAIT, wt);
      write_reg(REG_WINDOW, wn);
      write_reg(REG_FLAGS, fl);
      csr_valid <= 0;
   endtask

   // one walk through a schedule: re-arm, then mostly ticks at advancing time
   task automatic day_run(int start, int len);
      int t;
      t = start;
      send_item(CMD_ARM, t);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 19))
            0: send_item(CMD_ARM, t);
            1: send_item(CMD_PILOT, t);
            2: send_item(2'd3, $urandom_range(0, 131071));
            3: send_item(CMD_TICK, $urandom_range(0, 131071));
            default: send_item(CMD_TICK, t);
         endcase
         t += $urandom_range(0, 9) < 7 ? $urandom_range(1, 120) : $urandom_range(200, 2000);
         if (t > 86399) t = $urandom_range(0, 600);
      end
   endtask

   initial begin
      int iv;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, dense fixed gates, pilot mode, one fixed gate
      send_item(CMD_TICK, 0);
      send_item(CMD_TICK, 86399);
      send_item(2'd3, 131071);
      send_item(CMD_PILOT, 131071);
      drain();
      load_regs(MODE_FIXED, 10, 60, 10, 5, 0, 0, 3);
      send_item(CMD_ARM, 0);
      for (int t = 0; t < 4000; t += 300) send_item(CMD_TICK, 300 + t / 2);
      send_item(CMD_TICK, 3600);
      send_item(CMD_TICK, 3600);
      drain();
      load_regs(MODE_PILOT, 1439, 1439, 255, 127, 255, 255, 1);
      send_item(CMD_PILOT, 120000);
      send_item(CMD_TICK, 131071);
      send_item(CMD_TICK, 0);
      send_item(CMD_PILOT, 0);
      send_item(CMD_TICK, 0);
      drain();
      load_regs(MODE_FIXED, 0, 0, 0, 1, 0, 0, 3);
      send_item(CMD_ARM, 0);
      send_item(CMD_TICK, 0);
      send_item(CMD_TICK, 0);
      drain();

      // random phases of settings and schedules
      for (int ph = 0; ph < 32; ph++) begin
         iv = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 15);
         load_regs(ph % 8 == 7 ? 3 : (ph % 4 == 0 ? $urandom_range(0, 2) :
                   (ph % 2 ? MODE_FIXED : MODE_PILOT)),
                   $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 60),
                   $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(600, 1439),
                   iv,
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 8),
                   $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 3),
                   $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 5),
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : 3);
         if (ph == 5) long_hold = 1;
         day_run($urandom_range(0, 3) == 0 ? $urandom_range(0, 86399) : $urandom_range(0, 600),
                 48);
         drain();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (fail_count == 0)
         $display("start_gate_scheduler_core test passed");
      else
         $display("start_gate_scheduler_core test failed");
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("start_gate_scheduler_core test failed");
      $finish;
   end
endmodule
